### rtl/htfd_pkg.sv
package htfd_pkg;

  localparam int WORD_BYTES = 2;
  localparam int FRAME_LEN  = 2 * (WORD_BYTES + 1);
  localparam int POS_W      = $clog2(FRAME_LEN);
  localparam int IDX_W      = $clog2(WORD_BYTES + 1);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] CRC_IDX  = IDX_W'(WORD_BYTES);

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_MSB  = 8'h80;

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUMID_SCALE = 14'd10000;
  localparam logic [12:0] TEMP_OFFSET = 13'd4500;

  localparam int OUT_TDATA_W = 64;
  localparam int OUT_TUSER_W = 3;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [15:0] raw_humid;
    logic        temp_ok;
    logic        humid_ok;
    logic        frame_ok;
  } htfd_res_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_MSB) != 8'h00) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

### rtl/htfd_frame.sv
module htfd_frame (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                in_start,
  output logic                res_valid,
  input  logic                res_ready,
  output htfd_pkg::htfd_res_t res
);

  logic [htfd_pkg::POS_W-1:0] pos_r, pos_nxt, pos_cur;
  logic [htfd_pkg::IDX_W-1:0] idx_r, idx_nxt, idx_cur;
  logic [7:0]  crc_r, crc_nxt, crc_base;
  logic [7:0]  hi_r, hi_nxt, hi_base;
  logic [7:0]  lo_r, lo_nxt, lo_base;
  logic [15:0] pend_word_r, pend_word_nxt;
  logic        pend_ok_r, pend_ok_nxt;
  logic [15:0] st_temp_r, st_temp_nxt;
  logic [15:0] st_humid_r, st_humid_nxt;
  logic        res_v_r, res_v_nxt;
  htfd_pkg::htfd_res_t res_r, res_nxt;
  logic        acc, is_last, crc_good, both_ok;

  assign in_ready  = !res_v_r || res_ready;
  assign acc       = in_valid && in_ready;
  assign res_valid = res_v_r;
  assign res       = res_r;

  always_comb begin
    pos_cur  = in_start ? '0 : pos_r;
    idx_cur  = in_start ? '0 : idx_r;
    crc_base = (idx_cur == '0) ? htfd_pkg::CRC_INIT : crc_r;
    hi_base  = (idx_cur == '0) ? 8'h00 : hi_r;
    lo_base  = (idx_cur == '0) ? 8'h00 : lo_r;
    is_last  = (pos_cur == htfd_pkg::LAST_POS);
    crc_good = (crc_base == in_byte);
    both_ok  = pend_ok_r && crc_good;

    pos_nxt       = is_last ? '0 : pos_cur + 1'b1;
    idx_nxt       = (idx_cur == htfd_pkg::CRC_IDX) ? '0 : idx_cur + 1'b1;
    crc_nxt       = crc_base;
    hi_nxt        = hi_base;
    lo_nxt        = lo_base;
    pend_word_nxt = pend_word_r;
    pend_ok_nxt   = pend_ok_r;
    st_temp_nxt   = st_temp_r;
    st_humid_nxt  = st_humid_r;
    res_nxt       = res_r;

    if (idx_cur != htfd_pkg::CRC_IDX) begin
      crc_nxt = htfd_pkg::crc8_byte(crc_base, in_byte);
      hi_nxt  = lo_base;
      lo_nxt  = in_byte;
    end else if (!is_last) begin
      pend_word_nxt = {hi_base, lo_base};
      pend_ok_nxt   = crc_good;
    end else begin
      if (both_ok) begin
        st_temp_nxt  = pend_word_r;
        st_humid_nxt = {hi_base, lo_base};
      end
      res_nxt.raw_temp  = both_ok ? pend_word_r : st_temp_r;
      res_nxt.raw_humid = both_ok ? {hi_base, lo_base} : st_humid_r;
      res_nxt.temp_ok   = pend_ok_r;
      res_nxt.humid_ok  = crc_good;
      res_nxt.frame_ok  = both_ok;
    end

    if (acc) begin
      res_v_nxt = is_last && (idx_cur == htfd_pkg::CRC_IDX);
    end else if (res_ready) begin
      res_v_nxt = 1'b0;
    end else begin
      res_v_nxt = res_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      idx_r       <= '0;
      crc_r       <= htfd_pkg::CRC_INIT;
      hi_r        <= 8'h00;
      lo_r        <= 8'h00;
      pend_word_r <= 16'h0000;
      pend_ok_r   <= 1'b0;
      st_temp_r   <= 16'h0000;
      st_humid_r  <= 16'h0000;
      res_v_r     <= 1'b0;
    end else begin
      res_v_r <= res_v_nxt;
      if (acc) begin
        pos_r       <= pos_nxt;
        idx_r       <= idx_nxt;
        crc_r       <= crc_nxt;
        hi_r        <= hi_nxt;
        lo_r        <= lo_nxt;
        pend_word_r <= pend_word_nxt;
        pend_ok_r   <= pend_ok_nxt;
        st_temp_r   <= st_temp_nxt;
        st_humid_r  <= st_humid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= htfd_pkg::LAST_POS)
    else $error("frame position out of range");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= htfd_pkg::CRC_IDX)
    else $error("word byte index out of range");

  a_result_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> (res_v_r == $past(is_last)))
    else $error("result valid does not follow last byte of frame");

  a_frame_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res_v_r |-> (res_r.frame_ok == (res_r.temp_ok && res_r.humid_ok)))
    else $error("frame flag disagrees with CRC flags");

endmodule

### rtl/htfd_conv.sv
module htfd_conv (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  htfd_pkg::htfd_res_t                   in_res,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [htfd_pkg::OUT_TDATA_W-1:0]      out_data,
  output logic [htfd_pkg::OUT_TUSER_W-1:0]      out_user
);

  logic [30:0] temp_prod;
  logic [29:0] humid_prod;
  logic [16:0] temp_diff;
  logic        acc;
  logic        out_v_r;
  logic [htfd_pkg::OUT_TDATA_W-1:0] data_r, data_nxt;
  logic [htfd_pkg::OUT_TUSER_W-1:0] user_r, user_nxt;

  assign in_ready  = !out_v_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign out_valid = out_v_r;
  assign out_data  = data_r;
  assign out_user  = user_r;

  always_comb begin
    temp_prod  = 31'(in_res.raw_temp) * 31'(htfd_pkg::TEMP_SCALE);
    humid_prod = 30'(in_res.raw_humid) * 30'(htfd_pkg::HUMID_SCALE);
    temp_diff  = {2'b00, temp_prod[30:16]} - {4'b0000, htfd_pkg::TEMP_OFFSET};
    data_nxt   = {3'b000, in_res.raw_humid, in_res.raw_temp,
                  humid_prod[29:16], temp_diff[14:0]};
    user_nxt   = {in_res.frame_ok, in_res.humid_ok, in_res.temp_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (in_ready) begin
      out_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      data_r <= data_nxt;
      user_r <= user_nxt;
    end
  end

endmodule

### rtl/humidity_temp_frame_decoder_top.sv
// Sensor frame decoder: checks and converts one temperature/humidity frame.
// Input stream: one frame byte per transaction, MSB, LSB, CRC for the
// temperature word then the same for the humidity word. in_tuser high marks
// the first byte of a frame and restarts framing there.
// Output stream: one transaction per complete frame, carrying the CRC flags,
// the raw words held from the last good frame and their conversions to
// hundredths of a degree and hundredths of a percent.
// Path: input register, frame check register, conversion register.
// Throughput: one byte per cycle while in_tready is high; the CRC update is
// an unrolled byte step.
// Reset (rst_n low, synchronous) clears framing and the held words to zero,
// loads the running CRC with 0xFF and empties all stages.
// When the receiver stalls, the result waits in the output register; bytes
// keep flowing until a second finished result waits in the frame check
// register, and then in_tready drops until the output is taken.
module humidity_temp_frame_decoder_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [7:0]                            in_tdata,  // [7:0] rx_byte
  input  logic                                  in_tuser,  // [0] frame_start
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [14:0] temp_centideg, [28:15] humid_centipct, [44:29] raw_temp_word,
  // [60:45] raw_humid_word, [63:61] zero
  output logic [htfd_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // [0] temp_crc_good, [1] humid_crc_good, [2] frame_good
  output logic [htfd_pkg::OUT_TUSER_W-1:0]      out_tuser
);

  logic                in_v_r;
  logic [7:0]          in_byte_r;
  logic                in_start_r;
  logic                frm_ready;
  logic                frm_valid;
  logic                conv_ready;
  htfd_pkg::htfd_res_t frm_res;

  assign in_tready = !in_v_r || frm_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser;
    end
  end

  htfd_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_v_r),
    .in_ready  (frm_ready),
    .in_byte   (in_byte_r),
    .in_start  (in_start_r),
    .res_valid (frm_valid),
    .res_ready (conv_ready),
    .res       (frm_res)
  );

  htfd_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (frm_valid),
    .in_ready  (conv_ready),
    .in_res    (frm_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_user  (out_tuser)
  );

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

typedef struct packed {
  logic [14:0] temp_cdeg;
  logic [13:0] humid_cpct;
  logic [15:0] temp_raw;
  logic [15:0] humid_raw;
  logic        temp_ok;
  logic        humid_ok;
  logic        frame_ok;
} reading_t;

class frame_scoreboard;
  int unsigned slot;
  logic [7:0]  crc_acc;
  logic [7:0]  prev_byte;
  logic [7:0]  last_byte;
  logic [15:0] temp_hold;
  logic        temp_hold_ok;
  logic [15:0] temp_kept;
  logic [15:0] humid_kept;
  reading_t    readings_due[$];
  int          n_mismatch;
  int          n_frames;
  int          n_good;

  function new();
    slot         = 0;
    crc_acc      = htfd_pkg::CRC_INIT;
    prev_byte    = 8'h00;
    last_byte    = 8'h00;
    temp_hold    = 16'h0000;
    temp_hold_ok = 1'b0;
    temp_kept    = 16'h0000;
    humid_kept   = 16'h0000;
    n_mismatch   = 0;
    n_frames     = 0;
    n_good       = 0;
  endfunction

  static function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ htfd_pkg::CRC_POLY) : {r[6:0], 1'b0};
    return r;
  endfunction

  function int pending();
    return readings_due.size();
  endfunction

  // one accepted input transaction
  function void note_byte(logic [7:0] b, logic start);
    int unsigned pos;
    int unsigned sub;
    logic [15:0] word;
    logic        ok;
    int          t;
    int          h;
    reading_t    r;
    if (start) slot = 0;
    pos = slot;
    if (pos >= htfd_pkg::FRAME_LEN) pos = 0;
    sub = pos % (htfd_pkg::WORD_BYTES + 1);
    if (sub == 0) begin
      crc_acc   = htfd_pkg::CRC_INIT;
      prev_byte = 8'h00;
      last_byte = 8'h00;
    end
    slot = (pos + 1 >= htfd_pkg::FRAME_LEN) ? 0 : pos + 1;
    if (sub < htfd_pkg::WORD_BYTES) begin
      crc_acc   = crc_step(crc_acc, b);
      prev_byte = last_byte;
      last_byte = b;
      return;
    end
    word = {prev_byte, last_byte};
    ok   = (crc_acc == b);
    if (pos < htfd_pkg::FRAME_LEN - 1) begin
      temp_hold    = word;
      temp_hold_ok = ok;
      return;
    end
    if (temp_hold_ok && ok) begin
      temp_kept  = temp_hold;
      humid_kept = word;
    end
    t = (int'(temp_kept) * 17500) >>> 16;
    h = (int'(humid_kept) * 10000) >>> 16;
    r.temp_cdeg  = 15'(t - 4500);
    r.humid_cpct = 14'(h);
    r.temp_raw   = temp_kept;
    r.humid_raw  = humid_kept;
    r.temp_ok    = temp_hold_ok;
    r.humid_ok   = ok;
    r.frame_ok   = temp_hold_ok && ok;
    readings_due.push_back(r);
    n_frames++;
    if (r.frame_ok) n_good++;
  endfunction

  // one accepted output transaction
  function void check_reading(logic [63:0] d, logic [2:0] u);
    reading_t want;
    reading_t got;
    got.temp_cdeg  = d[14:0];
    got.humid_cpct = d[28:15];
    got.temp_raw   = d[44:29];
    got.humid_raw  = d[60:45];
    got.temp_ok    = u[0];
    got.humid_ok   = u[1];
    got.frame_ok   = u[2];
    if (readings_due.size() == 0) begin
      n_mismatch++;
      if (n_mismatch <= 10) $display("ERROR: unexpected result tdata=%h tuser=%b", d, u);
      return;
    end
    want = readings_due.pop_front();
    if (got.temp_cdeg !== want.temp_cdeg || got.humid_cpct !== want.humid_cpct ||
        got.temp_raw !== want.temp_raw || got.humid_raw !== want.humid_raw ||
        got.temp_ok !== want.temp_ok || got.humid_ok !== want.humid_ok ||
        got.frame_ok !== want.frame_ok || d[63:61] !== 3'b000) begin
      n_mismatch++;
      if (n_mismatch <= 10) begin
        $display("ERROR: reading mismatch at %0t", $realtime);
        $display("  exp temp=%0d humid=%0d raw=%h/%h ok=%b%b%b",
                 $signed(want.temp_cdeg), want.humid_cpct, want.temp_raw, want.humid_raw,
                 want.temp_ok, want.humid_ok, want.frame_ok);
        $display("  got temp=%0d humid=%0d raw=%h/%h ok=%b%b%b pad=%b",
                 $signed(got.temp_cdeg), got.humid_cpct, got.temp_raw, got.humid_raw,
                 got.temp_ok, got.humid_ok, got.frame_ok, d[63:61]);
      end
    end
  endfunction
endclass

module testbench;
  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;

  int              in_idle_pct = 24;
  int              out_idle_pct = 64;
  int              bytes_sent = 0;
  int              idle_cycles = 0;
  frame_scoreboard sb;

  humidity_temp_frame_decoder_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_byte(in_tdata, in_tuser);
      if (out_tvalid && out_tready) sb.check_reading(out_tdata, out_tuser);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic start);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  // sends the first n bytes of a frame; bad CRCs are flipped by a nonzero mask
  task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw, input bit tbad,
                            input bit hbad, input bit start, input int n);
    logic [7:0] fb [6];
    fb[0] = tw[15:8];
    fb[1] = tw[7:0];
    fb[2] = sb.crc_step(sb.crc_step(8'hFF, fb[0]), fb[1]);
    fb[3] = hw[15:8];
    fb[4] = hw[7:0];
    fb[5] = sb.crc_step(sb.crc_step(8'hFF, fb[3]), fb[4]);
    if (tbad) fb[2] ^= 8'($urandom_range(255, 1));
    if (hbad) fb[5] ^= 8'($urandom_range(255, 1));
    for (int i = 0; i < n; i++) send_byte(fb[i], (i == 0) && start);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_traffic(input int n_bytes);
    int target;
    int k;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      k = $urandom_range(99);
      if (k < 75) begin
        send_frame(pick_word(), pick_word(), $urandom_range(99) < 20,
                   $urandom_range(99) < 20, $urandom_range(99) < 85, 6);
      end else if (k < 88) begin
        send_frame(pick_word(), pick_word(), 0, 0, 1, $urandom_range(5, 1));
      end else begin
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom), $urandom_range(1));
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, restart mid-frame, missing start marker, bad CRCs
    send_frame(16'hFFFF, 16'hFFFF, 0, 0, 1, 6);
    send_frame(16'h1234, 16'h5678, 0, 0, 1, 2);
    send_frame(16'h0000, 16'h0000, 0, 0, 1, 6);
    send_frame(16'hA5A5, 16'h5A5A, 1, 0, 0, 6);
    send_frame(16'h6666, 16'h9999, 0, 1, 1, 6);

    random_traffic(250);
    in_idle_pct  = 64;
    out_idle_pct = 24;
    random_traffic(250);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    random_traffic(250);

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);

    $display("Sent %0d frame bytes under three handshake pressure mixes.", bytes_sent);
    $display("Checked %0d frame readings, %0d with both CRCs good.", sb.n_frames, sb.n_good);
    if (sb.n_mismatch == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d readings outstanding", sb.n_mismatch, sb.pending());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

### humidity_temp_frame_decoder_top.f
rtl/htfd_pkg.sv
rtl/htfd_frame.sv
rtl/htfd_conv.sv
rtl/humidity_temp_frame_decoder_top.sv
test/testbench.sv
